/* sv/bce_pkg.sv */
`default_nettype none

package bce_pkg;

  localparam int EPS_WIDTH  = 15;
  localparam int FUNC_WIDTH = 3;

  typedef enum logic [FUNC_WIDTH-1:0] {
    FN_LINEAR   = 3'd0,
    FN_QUAD     = 3'd1,
    FN_QUAD_D1  = 3'd2,
    FN_QUAD_D2  = 3'd3,
    FN_CUBIC    = 3'd4,
    FN_CUBIC_D1 = 3'd5,
    FN_CUBIC_D2 = 3'd6
  } func_t;

endpackage

`default_nettype wire

/* sv/bezier_curve_evaluator.sv */
// Bezier curve evaluator: linear, quadratic and cubic curves with first and
// second derivatives, one result item for every input item.
//
// s_* channel: s_tdata carries four signed fixed-point control points and the
// curve parameter t; s_tuser carries the function code. m_* channel: m_tdata
// carries the value, m_tuser the t_ok flag. The user must write the margin
// register (cfg_we, cfg_wdata) only while no item is in flight; unchecked.
//
// The datapath is a 12-stage pipeline: input register, operand selection,
// then three de Casteljau levels of three stages each (difference,
// multiply, round and add), then the scaling and output register. A new
// item can be accepted in every cycle unless the full pipe is stalled by
// m_tready. Each level has its own multipliers, one per lane, so nothing is
// shared between items.
//
// Reset empties the pipeline and sets the margin to 1. When m_tready is low
// the output register holds, and stages behind it keep moving until they
// run into an occupied stage; s_tready drops only once every stage is full.
`default_nettype none

module bezier_curve_evaluator
  import bce_pkg::*;
#(
  parameter int POINT_WIDTH = 32,
  parameter int T_FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [EPS_WIDTH-1:0] cfg_wdata,
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  // start_point, ctrl_one, ctrl_two, end_point, t_param
  input  wire logic [((4*POINT_WIDTH+T_FRAC_BITS+7)/8)*8-1:0] s_tdata,
  // func
  input  wire logic [FUNC_WIDTH-1:0] s_tuser,
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  // value
  output      logic [((POINT_WIDTH+8+7)/8)*8-1:0] m_tdata,
  // t_ok
  output      logic                 m_tuser
);

  localparam int W   = POINT_WIDTH;
  localparam int T   = T_FRAC_BITS;
  localparam int LW  = W + 2;
  localparam int DW  = LW + 1;
  localparam int PW  = DW + T + 1;
  localparam int VW  = W + 8;
  localparam int ODW = ((VW + 7) / 8) * 8;
  localparam int CW  = ((T > EPS_WIDTH) ? T : EPS_WIDTH) + 1;
  localparam int NS  = 12;
  localparam logic [PW-1:0] RND = PW'(1) << (T - 1);
  localparam logic [CW-1:0] ONE = CW'(1) << T;

  function automatic logic [LW-1:0] lerp_fin(input logic [LW-1:0] a, input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = p + RND;
    return a + r[T +: LW];
  endfunction

  function automatic logic [VW-1:0] sx_l(input logic [LW-1:0] v);
    return {{(VW-LW){v[LW-1]}}, v};
  endfunction

  function automatic logic [VW-1:0] sx_d(input logic [DW-1:0] v);
    return {{(VW-DW){v[DW-1]}}, v};
  endfunction

  // handshake and margin register
  logic [NS-1:0]        vld;
  logic [NS-1:0]        en;
  logic [EPS_WIDTH-1:0] t_eps;

  // stage registers
  logic [W-1:0]          s0_pt [0:3];
  logic [FUNC_WIDTH-1:0] s0_func;
  logic [LW-1:0]         s1_a [0:2];
  logic [LW-1:0]         s1_b [0:2];
  logic [LW-1:0]         s2_a [0:2];
  logic [DW-1:0]         s2_d [0:2];
  logic [LW-1:0]         s3_a [0:2];
  logic [PW-1:0]         s3_p [0:2];
  logic [LW-1:0]         s4_x [0:2];
  logic [LW-1:0]         s5_a [0:1];
  logic [DW-1:0]         s5_d [0:1];
  logic [LW-1:0]         s6_a [0:1];
  logic [PW-1:0]         s6_p [0:1];
  logic [LW-1:0]         s7_y [0:1];
  logic [LW-1:0]         s8_a;
  logic [DW-1:0]         s8_d;
  logic [LW-1:0]         s9_a;
  logic [PW-1:0]         s9_p;
  logic [LW-1:0]         s10_z;
  logic [VW-1:0]         out_value;
  logic                  out_ok;
  logic [FUNC_WIDTH-1:0] out_func;

  // values carried along the pipe
  logic [T-1:0]          t_s    [0:8];
  logic [FUNC_WIDTH-1:0] func_s [1:10];
  logic                  ok_s   [1:10];
  logic [LW-1:0]         qs_s   [1:10];
  logic [LW-1:0]         x0_s   [5:10];
  logic [DW-1:0]         dx_s   [6:10];
  logic [LW-1:0]         y0_s   [9:10];
  logic [DW-1:0]         dy_s   [9:10];

  // combinational
  logic [LW-1:0]        pe [0:3];
  logic [LW-1:0]        op_a [0:2];
  logic [LW-1:0]        op_b [0:2];
  logic [LW-1:0]        qsum;
  logic [LW-1:0]        dd0;
  logic [LW-1:0]        dd1;
  logic                 ok1;
  logic [CW-1:0]        t_ext;
  logic [CW-1:0]        e_ext;
  logic signed [PW-1:0] prod1 [0:2];
  logic signed [PW-1:0] prod2 [0:1];
  logic signed [PW-1:0] prod3;
  logic [VW-1:0]        value_next;

  always_comb begin
    en[NS-1] = !vld[NS-1] || m_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      t_eps <= EPS_WIDTH'(1);
    end else begin
      if (cfg_we) begin
        t_eps <= cfg_wdata;
      end
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // operand selection for the first level
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pe[i] = {{(LW-W){s0_pt[i][W-1]}}, s0_pt[i]};
    end
    qsum  = pe[3] - (pe[1] << 1) + pe[0];
    dd0   = pe[2] - (pe[1] << 1) + pe[0];
    dd1   = pe[3] - (pe[2] << 1) + pe[1];
    t_ext = CW'(t_s[0]);
    e_ext = CW'(t_eps);
    ok1   = !(t_ext < e_ext) && !(t_ext + e_ext > ONE);
    op_a[0] = pe[0];
    op_b[0] = pe[1];
    op_a[1] = pe[1];
    op_b[1] = pe[2];
    op_a[2] = pe[2];
    op_b[2] = pe[3];
    case (func_t'(s0_func))
      FN_LINEAR: begin
        op_b[0] = pe[3];
      end
      FN_QUAD, FN_QUAD_D1: begin
        op_b[1] = pe[3];
      end
      FN_QUAD_D2, FN_CUBIC, FN_CUBIC_D1: begin
      end
      FN_CUBIC_D2: begin
        op_a[0] = dd0;
        op_b[0] = dd1;
      end
      default: begin
        ok1 = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod1[i] = $signed(s2_d[i]) * $signed({1'b0, t_s[2]});
    end
    for (int i = 0; i < 2; i++) begin
      prod2[i] = $signed(s5_d[i]) * $signed({1'b0, t_s[5]});
    end
    prod3 = $signed(s8_d) * $signed({1'b0, t_s[8]});
  end

  always_comb begin
    case (func_t'(func_s[10]))
      FN_LINEAR:   value_next = sx_l(x0_s[10]);
      FN_QUAD:     value_next = sx_l(y0_s[10]);
      FN_QUAD_D1:  value_next = sx_d(dx_s[10]) << 1;
      FN_QUAD_D2:  value_next = sx_l(qs_s[10]) << 1;
      FN_CUBIC:    value_next = sx_l(s10_z);
      FN_CUBIC_D1: value_next = sx_d(dy_s[10]) + (sx_d(dy_s[10]) << 1);
      FN_CUBIC_D2: value_next = (sx_l(x0_s[10]) << 2) + (sx_l(x0_s[10]) << 1);
      default:     value_next = '0;
    endcase
    if (!ok_s[10]) begin
      value_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 4; i++) begin
        s0_pt[i] <= s_tdata[i*W +: W];
      end
      t_s[0]  <= s_tdata[4*W +: T];
      s0_func <= s_tuser;
    end
    if (en[1]) begin
      s1_a      <= op_a;
      s1_b      <= op_b;
      qs_s[1]   <= qsum;
      func_s[1] <= s0_func;
      ok_s[1]   <= ok1;
    end
    for (int k = 1; k <= 8; k++) begin
      if (en[k]) begin
        t_s[k] <= t_s[k-1];
      end
    end
    for (int k = 2; k <= 10; k++) begin
      if (en[k]) begin
        func_s[k] <= func_s[k-1];
        ok_s[k]   <= ok_s[k-1];
        qs_s[k]   <= qs_s[k-1];
      end
    end
    // first level
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        s2_a[i] <= s1_a[i];
        s2_d[i] <= {s1_b[i][LW-1], s1_b[i]} - {s1_a[i][LW-1], s1_a[i]};
      end
    end
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        s3_a[i] <= s2_a[i];
        s3_p[i] <= prod1[i];
      end
    end
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        s4_x[i] <= lerp_fin(s3_a[i], s3_p[i]);
      end
    end
    // second level
    if (en[5]) begin
      for (int i = 0; i < 2; i++) begin
        s5_a[i] <= s4_x[i];
        s5_d[i] <= {s4_x[i+1][LW-1], s4_x[i+1]} - {s4_x[i][LW-1], s4_x[i]};
      end
      x0_s[5] <= s4_x[0];
    end
    if (en[6]) begin
      for (int i = 0; i < 2; i++) begin
        s6_a[i] <= s5_a[i];
        s6_p[i] <= prod2[i];
      end
      dx_s[6] <= s5_d[0];
    end
    for (int k = 6; k <= 10; k++) begin
      if (en[k]) begin
        x0_s[k] <= x0_s[k-1];
      end
    end
    for (int k = 7; k <= 10; k++) begin
      if (en[k]) begin
        dx_s[k] <= dx_s[k-1];
      end
    end
    if (en[7]) begin
      for (int i = 0; i < 2; i++) begin
        s7_y[i] <= lerp_fin(s6_a[i], s6_p[i]);
      end
    end
    // third level
    if (en[8]) begin
      s8_a <= s7_y[0];
      s8_d <= {s7_y[1][LW-1], s7_y[1]} - {s7_y[0][LW-1], s7_y[0]};
    end
    if (en[9]) begin
      s9_a    <= s8_a;
      s9_p    <= prod3;
      y0_s[9] <= s8_a;
      dy_s[9] <= s8_d;
    end
    if (en[10]) begin
      s10_z    <= lerp_fin(s9_a, s9_p);
      y0_s[10] <= y0_s[9];
      dy_s[10] <= dy_s[9];
    end
    if (en[11]) begin
      out_value <= value_next;
      out_ok    <= ok_s[10];
      out_func  <= func_s[10];
    end
  end

  assign m_tvalid = vld[NS-1];
  assign m_tdata  = ODW'(out_value);
  assign m_tuser  = out_ok;

  // an illegal t or unused code always gives a zero value
  a_zero_when_bad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> out_value == '0)
    else $error("non-zero value with t_ok clear");

  // both second derivatives carry a factor of two
  a_second_even: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_func == FN_QUAD_D2 || out_func == FN_CUBIC_D2) |-> !out_value[0])
    else $error("odd second derivative");

  // a ready receiver must let the whole pipe move
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready && (&en))
    else $error("pipe stalled while output is ready");

  // a waiting result stays put
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(out_value) && $stable(out_ok))
    else $error("waiting result lost or changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && vld == '0)
    else $error("pipe not empty after reset");

endmodule

`default_nettype wire

/* bench/curve_checker.sv */
module curve_checker
  import bce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [EPS_WIDTH-1:0] cfg_wdata,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [143:0]         s_tdata,
  input  logic [FUNC_WIDTH-1:0] s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [39:0]          m_tdata,
  input  logic                 m_tuser,
  output int                   errors,
  output int                   outstanding
);

  typedef struct packed {
    logic [39:0] value;
    logic        t_ok;
  } curve_result_t;

  logic [EPS_WIDTH-1:0] margin;
  curve_result_t        due_values[$];
  curve_result_t        want;

  // one rounded de casteljau step, ties go towards +infinity
  function automatic longint blend(longint a, longint b, longint t);
    longint p;
    p = (b - a) * t + 64'sd32768;
    return a + (p >>> 16);
  endfunction

  function automatic curve_result_t eval_curve(logic [FUNC_WIDTH-1:0] fn, logic [143:0] pts,
                                               logic [EPS_WIDTH-1:0] eps_q);
    longint p0, p1, p2, pf, t, eps, a0, a1, a2, b0, b1, v;
    logic ok;
    curve_result_t r;
    p0  = longint'($signed(pts[31:0]));
    p1  = longint'($signed(pts[63:32]));
    p2  = longint'($signed(pts[95:64]));
    pf  = longint'($signed(pts[127:96]));
    t   = longint'(pts[143:128]);
    eps = longint'(eps_q);
    ok  = !(t < eps || t + eps > 64'sd65536);
    v   = 0;
    if (ok) begin
      case (fn)
        FN_LINEAR: v = blend(p0, pf, t);
        FN_QUAD, FN_QUAD_D1: begin
          a0 = blend(p0, p1, t);
          a1 = blend(p1, pf, t);
          v  = (fn == FN_QUAD) ? blend(a0, a1, t) : 2 * (a1 - a0);
        end
        FN_QUAD_D2: v = 2 * (pf - 2 * p1 + p0);
        FN_CUBIC, FN_CUBIC_D1: begin
          a0 = blend(p0, p1, t);
          a1 = blend(p1, p2, t);
          a2 = blend(p2, pf, t);
          b0 = blend(a0, a1, t);
          b1 = blend(a1, a2, t);
          v  = (fn == FN_CUBIC) ? blend(b0, b1, t) : 3 * (b1 - b0);
        end
        FN_CUBIC_D2: v = 6 * blend(p2 - 2 * p1 + p0, pf - 2 * p2 + p1, t);
        default: ok = 1'b0;
      endcase
    end
    r.value = ok ? v[39:0] : 40'd0;
    r.t_ok  = ok;
    return r;
  endfunction

  // printing stops after a hundred lines, counting does not
  task automatic report(string what);
    if (errors < 100) begin
      $display("mismatch at %0t: %s", $time, what);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      margin <= 15'd1;
    end else begin
      if (cfg_we) begin
        margin <= cfg_wdata;
      end
      if (s_tvalid && s_tready) begin
        due_values.push_back(eval_curve(s_tuser, s_tdata, margin));
      end
      if (m_tvalid && m_tready) begin
        if (due_values.size() == 0) begin
          report($sformatf("unexpected result item value=%h t_ok=%b", m_tdata, m_tuser));
        end else begin
          want = due_values.pop_front();
          if (m_tdata !== want.value) begin
            report($sformatf("value %h, predicted %h", m_tdata, want.value));
          end
          if (m_tuser !== want.t_ok) begin
            report($sformatf("t_ok %b, predicted %b", m_tuser, want.t_ok));
          end
        end
      end
    end
    outstanding <= due_values.size();
  end

endmodule

/* bench/testbench.sv */
module testbench;
  import bce_pkg::*;

  localparam logic [FUNC_WIDTH-1:0] FN_UNUSED = 3'd7;
  localparam logic [31:0] PT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] PT_MIN = 32'h8000_0000;
  localparam logic [31:0] PT_ONE = 32'h0001_0000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [EPS_WIDTH-1:0]  cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [143:0]          s_tdata = '0;
  logic [FUNC_WIDTH-1:0] s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [39:0]           m_tdata;
  logic                  m_tuser;

  int errors;
  int outstanding;
  int send_idle = 0;
  int recv_idle = 0;
  int cur_margin = 1;

  always #5 clk = ~clk;

  bezier_curve_evaluator dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  curve_checker watch (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .errors     (errors),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  task automatic offer_curve(logic [FUNC_WIDTH-1:0] fn, logic [31:0] p0, logic [31:0] p1,
                             logic [31:0] p2, logic [31:0] pf, logic [15:0] t);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {t, pf, p2, p1, p0};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold the input off until every predicted result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_margin(int m);
    drain();
    cfg_we     <= 1'b1;
    cfg_wdata  <= m[EPS_WIDTH-1:0];
    cur_margin = m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_point();
    case ($urandom_range(0, 7))
      0: return PT_MAX;
      1: return PT_MIN;
      2: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // bias t towards both edges of the legal window
  function automatic logic [15:0] pick_t();
    int t;
    case ($urandom_range(0, 3))
      0: t = cur_margin + $urandom_range(0, 4) - 2;
      1: t = 65536 - cur_margin + $urandom_range(0, 4) - 2;
      default: t = $urandom_range(0, 65535);
    endcase
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return t[15:0];
  endfunction

  function automatic logic [FUNC_WIDTH-1:0] pick_func();
    if ($urandom_range(0, 15) == 0) return FN_UNUSED;
    return FUNC_WIDTH'($urandom_range(0, 6));
  endfunction

  function automatic int margin_for(int k);
    case (k % 5)
      0: return 0;
      1: return 32767;
      2: return $urandom_range(0, 40);
      3: return $urandom_range(0, 32767);
      default: return $urandom_range(0, 600);
    endcase
  endfunction

  initial begin
    int guard;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle = 29;
    recv_idle = 61;
    // margin of one after reset: t of zero is out, t at either end just in
    offer_curve(FN_LINEAR, 32'd0, 32'd0, 32'd0, PT_ONE, 16'd0);
    offer_curve(FN_LINEAR, 32'd0, 32'd0, 32'd0, PT_ONE, 16'd1);
    offer_curve(FN_LINEAR, PT_MAX, 32'd0, 32'd0, PT_MIN, 16'hffff);
    // rounding ties in both directions
    offer_curve(FN_LINEAR, 32'd0, 32'd0, 32'd0, 32'd1, 16'h8000);
    offer_curve(FN_LINEAR, 32'd0, 32'd0, 32'd0, 32'hffff_ffff, 16'h8000);
    for (int f = 0; f < 7; f++) begin
      offer_curve(f[2:0], PT_MAX, PT_MIN, PT_MAX, PT_MIN, 16'h8000);
      offer_curve(f[2:0], PT_MIN, PT_MAX, PT_MIN, PT_MAX, 16'h3039);
    end
    offer_curve(FN_UNUSED, PT_MAX, PT_MIN, PT_MAX, PT_MIN, 16'h8000);

    // zero margin: every t is legal
    set_margin(0);
    offer_curve(FN_LINEAR, PT_MIN, 32'd0, 32'd0, PT_MAX, 16'd0);
    offer_curve(FN_CUBIC, PT_MAX, PT_MIN, PT_MAX, PT_MIN, 16'd0);
    offer_curve(FN_QUAD_D1, PT_MIN, PT_MAX, 32'd0, PT_MIN, 16'hffff);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 29 : (phase == 1) ? 61 : 0;
      recv_idle = (phase == 0) ? 61 : (phase == 1) ? 29 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        set_margin(margin_for(phase * 3 + seg + 1));
        repeat (190) begin
          offer_curve(pick_func(), pick_point(), pick_point(), pick_point(), pick_point(),
                      pick_t());
        end
      end
    end
    s_tvalid <= 1'b0;

    guard = 0;
    while (outstanding != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
